// File: hdl/dofb_pkg.sv
// shared constants, types and helpers for the doubled oled frame store flush block
package dofb_pkg;

  localparam int BUF_WIDTH_DEF   = 64;
  localparam int BUF_HEIGHT_DEF  = 32;
  localparam int STORE_DEPTH_DEF = ((BUF_HEIGHT_DEF + 7) / 8) * BUF_WIDTH_DEF;

  localparam int OP_W    = 2;
  localparam int COORD_W = 8;
  localparam int BYTE_W  = 8;

  localparam int CMD_BYTES       = 4;
  localparam int RESULTS_PER_SEG = 12;
  localparam int FETCH_BYTES     = 4;

  localparam logic [BYTE_W-1:0] CMD_PAGE_RANGE = 8'h22;
  localparam logic [BYTE_W-1:0] CMD_PAGE_START = 8'hb0;
  localparam logic [BYTE_W-1:0] CMD_COL_HIGH   = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_INVERT_ON  = 8'ha7;
  localparam logic [BYTE_W-1:0] CMD_INVERT_OFF = 8'ha6;
  localparam logic [BYTE_W-1:0] BYTE_ONES      = 8'hff;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL  = 2'd0,
    OP_FILL   = 2'd1,
    OP_INVERT = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_INVERT,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT,
    ST_DONE
  } state_t;

  // each stored pixel becomes two panel pixels in the column byte
  function automatic logic [BYTE_W-1:0] double_nibble(input logic [3:0] nib);
    return {{2{nib[3]}}, {2{nib[2]}}, {2{nib[1]}}, {2{nib[0]}}};
  endfunction

endpackage

// File: hdl/dofb_channels.sv
// request and result channel interfaces of the flush block
interface dofb_in_if
  import dofb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic               level;

  modport source (output valid, output op, output pixel_x, output pixel_y, output level,
                  input ready);
  modport sink (input valid, input op, input pixel_x, input pixel_y, input level,
                output ready);
endinterface

interface dofb_out_if
  import dofb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_data;
  logic              end_of_transfer;
  logic              flush_done;
  logic              last;

  modport source (output valid, output out_byte, output is_data, output end_of_transfer,
                  output flush_done, output last, input ready);
  modport sink (input valid, input out_byte, input is_data, input end_of_transfer,
                input flush_done, input last, output ready);
endinterface

// File: hdl/dofb_store.sv
// frame store memory: one write port, one read port with registered data
module dofb_store
  import dofb_pkg::*;
#(
  parameter int DEPTH = STORE_DEPTH_DEF,
  parameter int AW    = $clog2(STORE_DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/doubled_oled_framebuffer_dirty_flush_top.sv
// top level of the doubled oled frame store with dirty-area flush
//
// Holds a BUF_WIDTH x BUF_HEIGHT monochrome frame store (column bytes) shown at
// double size, plus one dirty flag per 8x8 area. Requests are taken one at a
// time. A pixel write reads the store byte, then modifies it and writes it
// back through the store's separate read and write ports. Set invert emits one
// command byte. Fill all and the clearing pass after reset sweep the store one
// byte a cycle over BUF_WIDTH * ceil(BUF_HEIGHT/8) bytes (256 at the default
// size), during which no request is taken. A flush step walks the segment
// cursor one position a cycle until it finds a dirty segment, then fetches four
// store bytes and emits its twelve bytes at one per cycle while the result side
// is ready. A flush step that finds nothing emits one done result and clears all
// flags. The output register lets the next request in while a result still
// waits.
module doubled_oled_framebuffer_dirty_flush_top
  import dofb_pkg::*;
#(
  parameter int BUF_WIDTH  = BUF_WIDTH_DEF,
  parameter int BUF_HEIGHT = BUF_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dofb_in_if.sink   in_ch,
  dofb_out_if.source out_ch
);

  localparam int BROWS  = (BUF_HEIGHT + 7) / 8;
  localparam int BAREAS = (BUF_WIDTH + 7) / 8;
  localparam int PAGES  = (BUF_HEIGHT + 3) / 4;
  localparam int SEGS   = (BUF_WIDTH + 3) / 4;
  localparam int DEPTH  = BROWS * BUF_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int RW     = (BROWS > 1) ? $clog2(BROWS) : 1;
  localparam int CW     = (BAREAS > 1) ? $clog2(BAREAS) : 1;
  localparam int PGW    = $clog2(PAGES + 1);
  localparam int SGW    = $clog2(SEGS);
  localparam int BXW    = SGW + 2;

  localparam logic [3:0] EMIT_LAST  = 4'(RESULTS_PER_SEG - 1);
  localparam logic [3:0] EMIT_DATA0 = 4'(CMD_BYTES);
  localparam logic [2:0] FETCH_DONE = 3'(FETCH_BYTES);

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] px_r, py_r;
  logic               lvl_r;
  logic [BYTE_W-1:0]  fill_r;
  logic [AW-1:0]      sweep_r;
  logic [PGW-1:0]     page_r, page_cur_r;
  logic [SGW-1:0]     seg_r, seg_cur_r;
  logic               dirty_r [BROWS][BAREAS];
  logic [2:0]         fetch_r;
  logic               cap_vld_r;
  logic [1:0]         cap_idx_r;
  logic               cap_zero_r;
  logic [BYTE_W-1:0]  colbuf_r [FETCH_BYTES];
  logic [3:0]         emit_r;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  ob_r;
  logic               data_r, eot_r, done_r, last_r;

  logic               out_ld;
  logic [BYTE_W-1:0]  ob_nxt;
  logic               data_nxt, eot_nxt, done_nxt, last_nxt;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]  mem_wdata, mem_rdata;

  logic               in_ready, accept, in_range, slot_free;
  op_t                in_op;
  logic               scan_end, scan_dirty, seg_wrap, sweep_end;
  logic [AW-1:0]      pix_addr, fetch_addr;
  logic [BYTE_W-1:0]  pix_bit;
  logic [BXW-1:0]     fetch_bx;
  logic               fetch_in;
  logic [3:0]         emit_d;
  logic [BYTE_W-1:0]  emit_src, emit_byte;
  logic [3:0]         emit_nib;
  logic               dirty_any;

  dofb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = in_ch.valid && in_ready;
  assign in_op     = op_t'(in_ch.op);
  assign in_range  = (int'(in_ch.pixel_x) < BUF_WIDTH) && (int'(in_ch.pixel_y) < BUF_HEIGHT);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign sweep_end = (int'(sweep_r) == DEPTH - 1);

  assign scan_end   = (int'(page_r) == PAGES);
  assign seg_wrap   = (int'(seg_r) == SEGS - 1);
  assign scan_dirty = !scan_end && dirty_r[RW'(page_r >> 1)][CW'(seg_r >> 1)];

  assign pix_addr = AW'(int'(py_r >> 3) * BUF_WIDTH + int'(px_r));
  assign pix_bit  = BYTE_W'(1) << py_r[2:0];

  // buffer column of the fetched byte: segment * 4 + fetch index
  assign fetch_bx   = {seg_cur_r, fetch_r[1:0]};
  assign fetch_in   = (int'(fetch_bx) < BUF_WIDTH);
  assign fetch_addr = AW'(int'(page_cur_r >> 1) * BUF_WIDTH + int'(fetch_bx));

  assign emit_d   = emit_r - EMIT_DATA0;
  assign emit_src = colbuf_r[emit_d[2:1]];
  assign emit_nib = page_cur_r[0] ? emit_src[7:4] : emit_src[3:0];

  always_comb begin
    emit_byte = double_nibble(emit_nib);
    if (emit_r < EMIT_DATA0) begin
      case (emit_r[1:0])
        2'd0:    emit_byte = CMD_PAGE_RANGE;
        2'd1:    emit_byte = CMD_PAGE_START | BYTE_W'(page_cur_r);
        2'd2:    emit_byte = {4'b0, seg_cur_r[0], 3'b0};
        2'd3:    emit_byte = CMD_COL_HIGH | BYTE_W'(seg_cur_r >> 1);
        default: emit_byte = CMD_PAGE_RANGE;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_PIXEL:  state_nxt = in_range ? ST_PIX_RD : ST_IDLE;
            OP_FILL:   state_nxt = ST_SWEEP;
            OP_INVERT: state_nxt = ST_INVERT;
            OP_FLUSH:  state_nxt = ST_SCAN;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: state_nxt = ST_PIX_WR;
      ST_PIX_WR: state_nxt = ST_IDLE;
      ST_INVERT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_DONE;
        else if (scan_dirty) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (fetch_r == FETCH_DONE) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && emit_r == EMIT_LAST) state_nxt = ST_IDLE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = fill_r;
    mem_re    = 1'b0;
    mem_raddr = pix_addr;
    out_ld    = 1'b0;
    ob_nxt    = '0;
    data_nxt  = 1'b0;
    eot_nxt   = 1'b0;
    done_nxt  = 1'b0;
    last_nxt  = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        mem_we = 1'b1;
      end
      ST_PIX_RD: begin
        mem_re = 1'b1;
      end
      ST_PIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pix_addr;
        mem_wdata = lvl_r ? (mem_rdata | pix_bit) : (mem_rdata & ~pix_bit);
      end
      ST_INVERT: begin
        out_ld   = slot_free;
        ob_nxt   = lvl_r ? CMD_INVERT_ON : CMD_INVERT_OFF;
        eot_nxt  = 1'b1;
        last_nxt = 1'b1;
      end
      ST_FETCH: begin
        // columns beyond the buffer are never read and show as blank
        mem_re    = !fetch_r[2] && fetch_in;
        mem_raddr = fetch_addr;
      end
      ST_EMIT: begin
        out_ld   = slot_free;
        ob_nxt   = emit_byte;
        data_nxt = (emit_r >= EMIT_DATA0);
        eot_nxt  = (emit_r < EMIT_DATA0) || (emit_r == EMIT_LAST);
        last_nxt = (emit_r == EMIT_LAST);
      end
      ST_DONE: begin
        out_ld   = slot_free;
        done_nxt = 1'b1;
        last_nxt = 1'b1;
      end
      default: begin
        out_ld = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      fill_r      <= '0;
      page_r      <= '0;
      seg_r       <= '0;
      fetch_r     <= '0;
      emit_r      <= '0;
      cap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < BROWS; r++) begin
        for (int c = 0; c < BAREAS; c++) begin
          dirty_r[r][c] <= 1'b1;
        end
      end
    end else begin
      state_r   <= state_nxt;
      cap_vld_r <= (state_r == ST_FETCH) && !fetch_r[2];

      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_SWEEP: begin
          sweep_r <= sweep_end ? '0 : sweep_r + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            fetch_r <= '0;
            emit_r  <= '0;
            if (in_op != OP_FLUSH) begin
              page_r <= '0;
              seg_r  <= '0;
            end
            if (in_op == OP_PIXEL && in_range) begin
              dirty_r[RW'(in_ch.pixel_y >> 3)][CW'(in_ch.pixel_x >> 3)] <= 1'b1;
            end
            if (in_op == OP_FILL) begin
              fill_r  <= in_ch.level ? BYTE_ONES : '0;
              sweep_r <= '0;
              for (int r = 0; r < BROWS; r++) begin
                for (int c = 0; c < BAREAS; c++) begin
                  dirty_r[r][c] <= 1'b1;
                end
              end
            end
          end
        end
        ST_SCAN: begin
          // the cursor moves past the position it examines, dirty or not
          if (!scan_end) begin
            if (seg_wrap) begin
              seg_r  <= '0;
              page_r <= page_r + 1'b1;
            end else begin
              seg_r <= seg_r + 1'b1;
            end
          end
        end
        ST_FETCH: begin
          fetch_r <= fetch_r + 1'b1;
        end
        ST_EMIT: begin
          if (slot_free) emit_r <= emit_r + 1'b1;
        end
        ST_DONE: begin
          if (slot_free) begin
            page_r <= '0;
            seg_r  <= '0;
            for (int r = 0; r < BROWS; r++) begin
              for (int c = 0; c < BAREAS; c++) begin
                dirty_r[r][c] <= 1'b0;
              end
            end
          end
        end
        default: begin
          fetch_r <= fetch_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r  <= in_ch.pixel_x;
      py_r  <= in_ch.pixel_y;
      lvl_r <= in_ch.level;
    end
    if (state_r == ST_SCAN && scan_dirty) begin
      page_cur_r <= page_r;
      seg_cur_r  <= seg_r;
    end
    cap_idx_r  <= fetch_r[1:0];
    cap_zero_r <= !fetch_in;
    if (cap_vld_r) begin
      colbuf_r[cap_idx_r] <= cap_zero_r ? '0 : mem_rdata;
    end
    if (out_ld) begin
      ob_r   <= ob_nxt;
      data_r <= data_nxt;
      eot_r  <= eot_nxt;
      done_r <= done_nxt;
      last_r <= last_nxt;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_byte        = ob_r;
  assign out_ch.is_data         = data_r;
  assign out_ch.end_of_transfer = eot_r;
  assign out_ch.flush_done      = done_r;
  assign out_ch.last            = last_r;

  always_comb begin
    dirty_any = 1'b0;
    for (int r = 0; r < BROWS; r++) begin
      for (int c = 0; c < BAREAS; c++) begin
        dirty_any = dirty_any | dirty_r[r][c];
      end
    end
  end

  a_done_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && slot_free) |=> !dirty_any)
    else $error("dirty flags not cleared after done result");

  a_store_port_single_use: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("store read and written in the same cycle");

  a_emit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_r <= EMIT_LAST))
    else $error("segment byte counter out of range");

  a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ld && state_r == ST_EMIT && last_nxt) |=> (state_r == ST_IDLE))
    else $error("segment did not finish after its last byte");

  a_scan_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (int'(page_r) <= PAGES))
    else $error("flush cursor beyond the last page");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the doubled oled frame store flush block
`timescale 1ns / 1ps

module testbench;
  import dofb_pkg::*;

  localparam int W         = BUF_WIDTH_DEF;
  localparam int H         = BUF_HEIGHT_DEF;
  localparam int ROWS      = (H + 7) / 8;
  localparam int AREAS     = (W + 7) / 8;
  localparam int PAGES     = (H + 3) / 4;
  localparam int SEGS      = (W + 3) / 4;
  localparam int POSITIONS = PAGES * SEGS;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              end_of_transfer;
    logic              flush_done;
    logic              last;
  } panel_byte_t;

  // mirror of the frame store, the area flags and the segment cursor
  class flush_scoreboard;
    logic [BYTE_W-1:0] store [ROWS][W];
    bit                dirty [ROWS][AREAS];
    int unsigned       cursor;
    panel_byte_t       pending [$];
    int unsigned       errors, checked;
    int unsigned       n_pixel, n_fill, n_invert, n_flush, n_done;

    function new();
      foreach (store[r, c]) store[r][c] = '0;
      foreach (dirty[r, a]) dirty[r][a] = 1'b1;
      cursor = 0;
    endfunction

    function void push(logic [BYTE_W-1:0] b, logic d, logic eot, logic dn, logic lst);
      panel_byte_t p;
      p.out_byte = b;
      p.is_data = d;
      p.end_of_transfer = eot;
      p.flush_done = dn;
      p.last = lst;
      pending.push_back(p);
    endfunction

    // one stored pixel becomes a 2x2 block on the panel
    function logic [BYTE_W-1:0] panel_column(int unsigned page, int unsigned col);
      int unsigned bx, by;
      logic [BYTE_W-1:0] nib, r;
      bx = col / 2;
      by = page / 2;
      r = '0;
      if (bx >= W || by >= ROWS) return '0;
      nib = store[by][bx];
      if (page % 2 == 1) nib = nib >> 4;
      for (int b = 0; b < 4; b++)
        if (nib[b]) r[2*b +: 2] = 2'b11;
      return r;
    endfunction

    // returns 1 when the request ends the flush with the done result
    function bit note_request(op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic lvl);
      int unsigned page, seg, col;
      case (op)
        OP_PIXEL: begin
          n_pixel++;
          cursor = 0;
          if (x < W && y < H) begin
            store[y / 8][x][y % 8] = lvl;
            dirty[y / 8][x / 8] = 1'b1;
          end
          return 1'b0;
        end
        OP_FILL: begin
          n_fill++;
          cursor = 0;
          foreach (store[r, c]) store[r][c] = lvl ? BYTE_ONES : '0;
          foreach (dirty[r, a]) dirty[r][a] = 1'b1;
          return 1'b0;
        end
        OP_INVERT: begin
          n_invert++;
          cursor = 0;
          push(lvl ? CMD_INVERT_ON : CMD_INVERT_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
          return 1'b0;
        end
        default: begin
          n_flush++;
          for (int unsigned p = cursor; p < POSITIONS; p++) begin
            page = p / SEGS;
            seg = p % SEGS;
            if (dirty[page / 2][seg / 2]) begin
              col = seg * 8;
              push(CMD_PAGE_RANGE, 1'b0, 1'b1, 1'b0, 1'b0);
              push(CMD_PAGE_START | BYTE_W'(page), 1'b0, 1'b1, 1'b0, 1'b0);
              push(BYTE_W'(col % 16), 1'b0, 1'b1, 1'b0, 1'b0);
              push(CMD_COL_HIGH | BYTE_W'((col / 16) % 16), 1'b0, 1'b1, 1'b0, 1'b0);
              for (int i = 0; i < 8; i++)
                push(panel_column(page, col + i), 1'b1, i == 7, 1'b0, i == 7);
              cursor = p + 1;
              return 1'b0;
            end
          end
          foreach (dirty[r, a]) dirty[r][a] = 1'b0;
          cursor = 0;
          n_done++;
          push('0, 1'b0, 1'b0, 1'b1, 1'b1);
          return 1'b1;
        end
      endcase
    endfunction

    function void check_result(panel_byte_t seen);
      panel_byte_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: unexpected result byte=%h data=%b eot=%b done=%b last=%b",
                   $realtime, seen.out_byte, seen.is_data, seen.end_of_transfer,
                   seen.flush_done, seen.last);
        return;
      end
      want = pending.pop_front();
      if (seen !== want) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("%0t: mismatch expected byte=%h data=%b eot=%b done=%b last=%b",
                   $realtime, want.out_byte, want.is_data, want.end_of_transfer,
                   want.flush_done, want.last);
          $display("    got byte=%h data=%b eot=%b done=%b last=%b",
                   seen.out_byte, seen.is_data, seen.end_of_transfer,
                   seen.flush_done, seen.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dofb_in_if  in_ch ();
  dofb_out_if out_ch ();

  doubled_oled_framebuffer_dirty_flush_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  flush_scoreboard board;
  bit              steady_tx;
  int unsigned     sent;
  int unsigned     rx_stall = 0;
  int unsigned     rx_calm = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.level = 1'b0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(int unsigned limit);
    if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 255));
    return COORD_W'($urandom_range(0, limit - 1));
  endfunction

  // result side: random stalls with calm stretches in between
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_calm > 0) rx_calm <= rx_calm - 1;
      else if ($urandom_range(0, 99) < 4) rx_calm <= $urandom_range(50, 300);
      else if ($urandom_range(0, 99) < 30) rx_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin : sample_results
    panel_byte_t seen;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.out_byte = out_ch.out_byte;
      seen.is_data = out_ch.is_data;
      seen.end_of_transfer = out_ch.end_of_transfer;
      seen.flush_done = out_ch.flush_done;
      seen.last = out_ch.last;
      board.check_result(seen);
    end
  end

  // valid stays high into the next request when there is no gap
  task automatic send_request(op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic lvl, output bit saw_done);
    int unsigned gap;
    gap = steady_tx ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_gap());
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pixel_x <= x;
    in_ch.pixel_y <= y;
    in_ch.level <= lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    saw_done = board.note_request(op, x, y, lvl);
    sent++;
  endtask

  task automatic send(op_t op, int x, int y, bit lvl);
    bit d;
    send_request(op, COORD_W'(x), COORD_W'(y), lvl, d);
  endtask

  task automatic send_pixel();
    send(OP_PIXEL, rand_coord(W), rand_coord(H), $urandom_range(0, 1));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // flush steps until the done result or the step limit
  task automatic flush_run(int unsigned limit);
    bit d;
    int unsigned steps;
    d = 1'b0;
    steps = 0;
    while (!d && steps < limit) begin
      send_request(OP_FLUSH, COORD_W'($urandom), COORD_W'($urandom), $urandom_range(0, 1), d);
      steps++;
    end
  endtask

  task automatic run_sequence();
    int unsigned n;
    steady_tx = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 11) == 0)
      send(OP_FILL, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
    n = $urandom_range(1, 6);
    repeat (n) send_pixel();
    if ($urandom_range(0, 3) == 0)
      send(OP_INVERT, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
    // some runs are cut short so the cursor restarts mid-frame
    if ($urandom_range(0, 4) == 0) flush_run($urandom_range(0, 6));
    else flush_run(POSITIONS + 1);
    if ($urandom_range(0, 5) == 0)
      send(op_t'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) wait_drain();
  endtask

  initial begin
    board = new();
    steady_tx = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: flush from reset, invert both ways, fills, corners, out-of-frame writes
    send(OP_FLUSH, 0, 0, 0);
    send(OP_FLUSH, 255, 255, 1);
    send(OP_INVERT, 0, 0, 1);
    send(OP_INVERT, 255, 255, 0);
    send(OP_FILL, 0, 0, 1);
    send(OP_FLUSH, 0, 0, 0);
    send(OP_PIXEL, 0, 0, 0);
    send(OP_PIXEL, W - 1, H - 1, 0);
    send(OP_PIXEL, W - 1, 0, 0);
    send(OP_PIXEL, 0, H - 1, 0);
    send(OP_FLUSH, 0, 0, 0);
    send(OP_FLUSH, 0, 0, 0);
    send(OP_FILL, 255, 255, 0);
    send(OP_PIXEL, 0, 0, 1);
    send(OP_PIXEL, W - 1, H - 1, 1);
    send(OP_PIXEL, 7, 7, 1);
    send(OP_PIXEL, 7, 7, 0);
    send(OP_PIXEL, W, 0, 1);
    send(OP_PIXEL, 0, H, 1);
    send(OP_PIXEL, 255, 255, 1);
    send(OP_PIXEL, 128, 200, 1);
    send(OP_FLUSH, 0, 0, 1);
    send(OP_FLUSH, 0, 0, 1);

    // hold the request side until the last result is out
    wait_drain();

    // first random run walks the whole frame to the done result
    send(OP_FILL, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
    repeat (24) send_pixel();
    flush_run(POSITIONS + 1);
    while (sent < 180) run_sequence();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    // a fill accepted last may still be sweeping the store
    repeat (400) @(posedge clk);

    $display("covered %0d requests: %0d pixel writes, %0d fills, %0d inverts, %0d flush steps",
             sent, board.n_pixel, board.n_fill, board.n_invert, board.n_flush);
    $display("checked %0d panel bytes, %0d full-frame flushes, %0d errors",
             board.checked, board.n_done, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
